FILE: rtl/gpms_pkg.sv
// Shared types and constants for the game pad mouse serial slave.
`timescale 1ns / 1ps

package gpms_pkg;

  // Item kinds carried in the func field of an input beat.
  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_MOUSE    = 2'd1,
    FUNC_PAD      = 2'd2,
    FUNC_OVERFLOW = 2'd3
  } func_t;

  // What the next exchange answers as.
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_PAD   = 2'd1,
    MODE_MOUSE = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam logic REG_ACK_DELAY = 1'b0;
  localparam logic REG_ACK_WIDTH = 1'b1;

  localparam int unsigned TICK_W = 10;
  localparam logic [TICK_W-1:0] ACK_DELAY_RST = 10'd60;
  localparam logic [TICK_W-1:0] ACK_WIDTH_RST = 10'd16;

  // Protocol bytes.
  localparam logic [7:0] CMD_START   = 8'h01;
  localparam logic [7:0] CMD_POLL    = 8'h42;
  localparam logic [7:0] ID_MOUSE    = 8'h12;
  localparam logic [7:0] ID_PAD      = 8'h41;
  localparam logic [7:0] ID_READY    = 8'h5A;
  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] BYTE_CNT_MAX = 8'hFF;

  localparam int unsigned RESP_DEPTH = 6;
  localparam logic [2:0] RESP_SIZE_MOUSE = 3'd6;
  localparam logic [2:0] RESP_SIZE_PAD   = 3'd4;

  typedef struct packed {
    func_t              func;
    logic               att_level;
    logic               clk_level;
    logic               cmd_level;
    logic signed [7:0]  delta_x;
    logic signed [7:0]  delta_y;
    logic               left_button;
    logic               right_button;
    logic [15:0]        pad_buttons;
  } in_item_t;

  typedef struct packed {
    logic dat_low;
    logic ack_low;
  } out_item_t;

  // Report state the link latches into its response at the first byte.
  typedef struct packed {
    mode_t             mode;
    logic signed [7:0] sum_x;
    logic signed [7:0] sum_y;
    logic              left_held;
    logic              right_held;
    logic [15:0]       pad_buttons;
  } rpt_state_t;

endpackage

FILE: rtl/gpms_report.sv
// Report accumulator: movement sums, held buttons and protocol mode.
`timescale 1ns / 1ps

module gpms_report (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  gpms_pkg::in_item_t   item,
  input  logic                 clear_sums,
  output gpms_pkg::rpt_state_t rpt
);

  localparam logic signed [8:0] SAT_MAX = 9'sd127;
  localparam logic signed [8:0] SAT_MIN = -9'sd128;

  gpms_pkg::rpt_state_t rpt_r, rpt_nxt;

  function automatic logic signed [7:0] sat_add(input logic signed [7:0] a,
                                                input logic signed [7:0] b);
    logic signed [8:0] s;
    s = {a[7], a} + {b[7], b};
    if (s > SAT_MAX) begin
      sat_add = SAT_MAX[7:0];
    end else if (s < SAT_MIN) begin
      sat_add = SAT_MIN[7:0];
    end else begin
      sat_add = s[7:0];
    end
  endfunction

  always_comb begin
    rpt_nxt = rpt_r;
    if (clear_sums) begin
      rpt_nxt.sum_x = '0;
      rpt_nxt.sum_y = '0;
    end
    if (upd) begin
      case (item.func)
        gpms_pkg::FUNC_MOUSE: begin
          rpt_nxt.sum_x      = sat_add(rpt_r.sum_x, item.delta_x);
          rpt_nxt.sum_y      = sat_add(rpt_r.sum_y, item.delta_y);
          rpt_nxt.left_held  = item.left_button;
          rpt_nxt.right_held = item.right_button;
          rpt_nxt.mode       = gpms_pkg::MODE_MOUSE;
        end
        gpms_pkg::FUNC_PAD: begin
          rpt_nxt.sum_x       = '0;
          rpt_nxt.sum_y       = '0;
          rpt_nxt.pad_buttons = item.pad_buttons;
          rpt_nxt.mode        = gpms_pkg::MODE_PAD;
        end
        gpms_pkg::FUNC_OVERFLOW: begin
          rpt_nxt.sum_x = '0;
          rpt_nxt.sum_y = '0;
          rpt_nxt.mode  = gpms_pkg::MODE_PAD;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_r <= '{mode: gpms_pkg::MODE_NONE, default: '0};
    end else begin
      rpt_r <= rpt_nxt;
    end
  end

  assign rpt = rpt_r;

endmodule

FILE: rtl/gpms_link.sv
// Serial link phase machine: command capture, response shifting, hold and acknowledge.
`timescale 1ns / 1ps

module gpms_link (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             tick,
  input  gpms_pkg::in_item_t               item,
  input  logic [gpms_pkg::TICK_W-1:0]      ack_delay,
  input  logic [gpms_pkg::TICK_W-1:0]      ack_width,
  input  gpms_pkg::rpt_state_t             rpt,
  output logic                             clear_sums,
  output gpms_pkg::out_item_t              drive_nxt
);

  typedef enum logic [2:0] {
    PH_ATT_LOW  = 3'd0,
    PH_IDLE     = 3'd1,
    PH_CLK_HIGH = 3'd2,
    PH_CLK_LOW  = 3'd3,
    PH_HOLD     = 3'd4,
    PH_ACK      = 3'd5
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [2:0]                  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]                  cmd0_r, cmd0_nxt;
  logic [7:0]                  cmd1_r, cmd1_nxt;
  logic [7:0]                  resp_r [gpms_pkg::RESP_DEPTH];
  logic [7:0]                  resp_nxt [gpms_pkg::RESP_DEPTH];
  logic [2:0]                  resp_size_r, resp_size_nxt;
  logic [gpms_pkg::TICK_W-1:0] wait_r, wait_nxt;
  logic                        ack_r, ack_nxt;
  logic                        dat_r, dat_nxt;

  logic       do_finish;
  logic [2:0] rd_idx;
  logic [7:0] rd_byte;
  logic       rd_ok;
  logic [7:0] byte_size;

  assign byte_size = {5'd0, resp_size_r};
  assign rd_idx    = byte_cnt_r[2:0] - 3'd1;
  assign rd_ok     = (byte_cnt_r != 8'd0) && (byte_cnt_r <= byte_size) &&
                     (byte_cnt_r <= 8'(gpms_pkg::RESP_DEPTH));
  assign rd_byte   = rd_ok ? resp_r[rd_idx] : 8'd0;

  always_comb begin
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    cmd0_nxt      = cmd0_r;
    cmd1_nxt      = cmd1_r;
    resp_nxt      = resp_r;
    resp_size_nxt = resp_size_r;
    wait_nxt      = wait_r;
    ack_nxt       = ack_r;
    dat_nxt       = dat_r;
    do_finish     = 1'b0;
    clear_sums    = 1'b0;

    if (tick) begin
      unique case (phase_r)
        PH_IDLE: begin
          dat_nxt = 1'b0;
          if (!item.att_level) begin
            bit_cnt_nxt  = '0;
            byte_cnt_nxt = '0;
            cmd0_nxt     = '0;
            cmd1_nxt     = '0;
            phase_nxt    = PH_CLK_HIGH;
          end
        end
        PH_CLK_HIGH: begin
          if (!item.clk_level) begin
            phase_nxt = PH_CLK_LOW;
            if (rd_ok) begin
              dat_nxt = !rd_byte[bit_cnt_r];
            end
          end else if (item.att_level) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_CLK_LOW: begin
          if (item.clk_level) begin
            if (item.cmd_level && byte_cnt_r == 8'd0) begin
              cmd0_nxt[bit_cnt_r] = 1'b1;
            end
            if (item.cmd_level && byte_cnt_r == 8'd1) begin
              cmd1_nxt[bit_cnt_r] = 1'b1;
            end
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            if (bit_cnt_r == 3'd7) begin
              wait_nxt  = ack_delay;
              phase_nxt = PH_HOLD;
            end else begin
              phase_nxt = PH_CLK_HIGH;
            end
          end else if (item.att_level) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_HOLD: begin
          if (wait_r != '0) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            dat_nxt = 1'b0;
            if (byte_cnt_r < byte_size && ack_width != '0) begin
              ack_nxt   = 1'b1;
              wait_nxt  = ack_width - 1'b1;
              phase_nxt = PH_ACK;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        PH_ACK: begin
          if (wait_r != '0) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            ack_nxt   = 1'b0;
            do_finish = 1'b1;
          end
        end
        default: begin
          dat_nxt   = 1'b0;
          phase_nxt = item.att_level ? PH_IDLE : PH_ATT_LOW;
        end
      endcase
    end

    // End of a byte: check the command header, latch the answer on the first byte.
    if (do_finish) begin
      if ((byte_cnt_r == 8'd0 && cmd0_r != gpms_pkg::CMD_START) ||
          (byte_cnt_r == 8'd1 && cmd1_r != gpms_pkg::CMD_POLL)) begin
        phase_nxt = PH_ATT_LOW;
      end else begin
        if (byte_cnt_r == 8'd0) begin
          clear_sums  = 1'b1;
          resp_nxt[1] = gpms_pkg::ID_READY;
          case (rpt.mode)
            gpms_pkg::MODE_MOUSE: begin
              resp_size_nxt = gpms_pkg::RESP_SIZE_MOUSE;
              resp_nxt[0]   = gpms_pkg::ID_MOUSE;
              resp_nxt[2]   = gpms_pkg::BYTE_IDLE;
              resp_nxt[3]   = {4'hF, !rpt.left_held, !rpt.right_held, 2'b00};
              resp_nxt[4]   = rpt.sum_x;
              resp_nxt[5]   = rpt.sum_y;
            end
            gpms_pkg::MODE_PAD: begin
              resp_size_nxt = gpms_pkg::RESP_SIZE_PAD;
              resp_nxt[0]   = gpms_pkg::ID_PAD;
              resp_nxt[2]   = ~rpt.pad_buttons[7:0];
              resp_nxt[3]   = ~rpt.pad_buttons[15:8];
            end
            default: begin
              resp_size_nxt = gpms_pkg::RESP_SIZE_PAD;
              resp_nxt[0]   = gpms_pkg::ID_PAD;
              resp_nxt[2]   = gpms_pkg::BYTE_IDLE;
              resp_nxt[3]   = gpms_pkg::BYTE_IDLE;
            end
          endcase
        end
        if (byte_cnt_r != gpms_pkg::BYTE_CNT_MAX) begin
          byte_cnt_nxt = byte_cnt_r + 8'd1;
        end
        phase_nxt = PH_CLK_HIGH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ATT_LOW;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      cmd0_r      <= '0;
      cmd1_r      <= '0;
      resp_size_r <= '0;
      wait_r      <= '0;
      ack_r       <= 1'b0;
      dat_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      cmd0_r      <= cmd0_nxt;
      cmd1_r      <= cmd1_nxt;
      resp_size_r <= resp_size_nxt;
      wait_r      <= wait_nxt;
      ack_r       <= ack_nxt;
      dat_r       <= dat_nxt;
    end
  end

  // Response bytes are only read after they have been latched.
  always_ff @(posedge clk) begin
    resp_r <= resp_nxt;
  end

  assign drive_nxt.dat_low = dat_nxt;
  assign drive_nxt.ack_low = ack_nxt;

endmodule

FILE: rtl/game_pad_mouse_serial_slave_top.sv
// Top level of the game pad mouse serial slave: handshakes, configuration and result register.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Beat payload
// ---------+-----------+--------------------+-------------------------------------------
// in_      | input     | in_valid/in_ready  | in_item_t: pin sample tick or report event
// out_     | output    | out_valid/out_ready| out_item_t: data and acknowledge line drive
// cfg_     | input     | cfg_we             | ack_delay_ticks (0), ack_width_ticks (1)
//
// For every accepted input beat, the phase machine and the report unit update their
// state at the accepting edge, and the resulting line drive lands in the output register.
// One beat per clock while out_ready stays high; the output register is the only stage on the path.
// in_ready is high whenever the output register is empty or is being emptied this cycle,
// so a stalled consumer stops input after exactly one held result.
// Reset is synchronous and active low; after reset the link waits to see attention high.
module game_pad_mouse_serial_slave_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gpms_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gpms_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [gpms_pkg::TICK_W-1:0]   cfg_wdata
);

  logic [gpms_pkg::TICK_W-1:0] ack_delay_r;
  logic [gpms_pkg::TICK_W-1:0] ack_width_r;

  logic                 in_fire;
  logic                 tick;
  logic                 rpt_upd;
  logic                 clear_sums;
  gpms_pkg::rpt_state_t rpt;
  gpms_pkg::out_item_t  drive_nxt;
  logic                 out_valid_r;
  gpms_pkg::out_item_t  out_data_r;

  // A result waits in the output register; a new beat is taken if it leaves now.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign tick     = in_fire && (in_data.func == gpms_pkg::FUNC_TICK);
  assign rpt_upd  = in_fire && (in_data.func != gpms_pkg::FUNC_TICK);

  // Write configuration registers only while the link is quiet; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_delay_r <= gpms_pkg::ACK_DELAY_RST;
      ack_width_r <= gpms_pkg::ACK_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpms_pkg::REG_ACK_DELAY: ack_delay_r <= cfg_wdata;
        gpms_pkg::REG_ACK_WIDTH: ack_width_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gpms_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (rpt_upd),
    .item       (in_data),
    .clear_sums (clear_sums),
    .rpt        (rpt)
  );

  gpms_link u_link (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .item       (in_data),
    .ack_delay  (ack_delay_r),
    .ack_width  (ack_width_r),
    .rpt        (rpt),
    .clear_sums (clear_sums),
    .drive_nxt  (drive_nxt)
  );

  // Every accepted beat yields exactly one result beat with the updated line drive.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/gpms_checker.sv
// Port-level checks for the game pad mouse serial slave, bound to its top level.
`timescale 1ns / 1ps

module gpms_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gpms_pkg::out_item_t out_data
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // Each accepted beat produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Acknowledge is only driven after the data line has been released.
  a_ack_data_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.ack_low) |-> !out_data.dat_low)
    else $error("acknowledge driven while data held low");

endmodule

bind game_pad_mouse_serial_slave_top gpms_checker u_gpms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the pad link slave: drives pin samples and reports, checks line drive.
`timescale 1ns / 1ps

// The bench plays the host side of the pad serial link. Stimulus goes in one beat at a time
// through the in_ channel. Each accepted beat is run at once through a built-in model of the
// slave, which yields the data and acknowledge drive that the block must report for that beat.
// A checker at the rising edge compares every out_ beat, field by field, with the oldest
// expected drive. Both channels idle at random, and a watchdog bounds the run.
//
// The model's phase machine also steers the stimulus. While the slave holds or acknowledges
// after a byte, the host keeps sending ticks until the model leaves those phases. This keeps the
// exchanges well formed whatever the acknowledge timing is.
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_BEATS = 350;

  // Button bits of the mouse status byte, before inversion.
  localparam logic [7:0] BTN_FIXED = 8'h03;
  localparam logic [7:0] BTN_LEFT  = 8'h08;
  localparam logic [7:0] BTN_RIGHT = 8'h04;

  typedef enum logic [2:0] {
    PH_ATT_LOW  = 3'd0,
    PH_IDLE     = 3'd1,
    PH_CLK_HIGH = 3'd2,
    PH_CLK_LOW  = 3'd3,
    PH_HOLD     = 3'd4,
    PH_ACK      = 3'd5
  } link_phase_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  gpms_pkg::in_item_t            in_data;
  logic                          out_valid;
  logic                          out_ready;
  gpms_pkg::out_item_t           out_data;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [gpms_pkg::TICK_W-1:0]   cfg_wdata;

  // Bench bookkeeping.
  gpms_pkg::out_item_t expected_drive_q[$];
  int unsigned         mismatch_count;
  int unsigned         beats_sent;
  int unsigned         cycle_count;
  logic                idle_on;

  // Model of the slave: timing registers, link state and report state.
  logic [gpms_pkg::TICK_W-1:0] ack_delay;
  logic [gpms_pkg::TICK_W-1:0] ack_width;
  link_phase_t                 link_phase;
  logic [2:0]                  bit_cnt;
  logic [7:0]                  byte_cnt;
  logic [7:0]                  cmd_byte [2];
  logic [7:0]                  resp_byte [gpms_pkg::RESP_DEPTH];
  logic [2:0]                  resp_size;
  gpms_pkg::mode_t             report_mode;
  logic signed [7:0]           sum_x;
  logic signed [7:0]           sum_y;
  logic                        left_held;
  logic                        right_held;
  logic [15:0]                 pad_held;
  logic [gpms_pkg::TICK_W-1:0] wait_cnt;
  logic                        ack_on;
  logic                        dat_on;

  game_pad_mouse_serial_slave_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------------------------
  // Link model
  // ------------------------------------------------------------------------------------------

  function automatic void reset_link_model();
    ack_delay   = gpms_pkg::ACK_DELAY_RST;
    ack_width   = gpms_pkg::ACK_WIDTH_RST;
    link_phase  = PH_ATT_LOW;
    bit_cnt     = '0;
    byte_cnt    = '0;
    cmd_byte[0] = '0;
    cmd_byte[1] = '0;
    for (int i = 0; i < gpms_pkg::RESP_DEPTH; i++) resp_byte[i] = '0;
    resp_size   = '0;
    report_mode = gpms_pkg::MODE_NONE;
    sum_x       = '0;
    sum_y       = '0;
    left_held   = 1'b0;
    right_held  = 1'b0;
    pad_held    = '0;
    wait_cnt    = '0;
    ack_on      = 1'b0;
    dat_on      = 1'b0;
  endfunction

  // Movement sums clamp to the signed byte range instead of wrapping.
  function automatic logic signed [7:0] sat_sum8(logic signed [7:0] acc,
                                                 logic signed [7:0] delta);
    logic signed [8:0] total;
    total = {acc[7], acc} + {delta[7], delta};
    if (total > 9'sd127) total = 9'sd127;
    if (total < -9'sd128) total = -9'sd128;
    return total[7:0];
  endfunction

  // The first byte of an exchange freezes the reply from the report state and clears the sums.
  function automatic void latch_reply();
    logic [7:0] buttons;
    buttons = BTN_FIXED | (left_held ? BTN_LEFT : 8'h00) | (right_held ? BTN_RIGHT : 8'h00);
    case (report_mode)
      gpms_pkg::MODE_MOUSE: begin
        resp_size    = gpms_pkg::RESP_SIZE_MOUSE;
        resp_byte[0] = gpms_pkg::ID_MOUSE;
        resp_byte[1] = gpms_pkg::ID_READY;
        resp_byte[2] = gpms_pkg::BYTE_IDLE;
        resp_byte[3] = ~buttons;
        resp_byte[4] = sum_x;
        resp_byte[5] = sum_y;
      end
      gpms_pkg::MODE_PAD: begin
        resp_size    = gpms_pkg::RESP_SIZE_PAD;
        resp_byte[0] = gpms_pkg::ID_PAD;
        resp_byte[1] = gpms_pkg::ID_READY;
        resp_byte[2] = ~pad_held[7:0];
        resp_byte[3] = ~pad_held[15:8];
      end
      default: begin
        resp_size    = gpms_pkg::RESP_SIZE_PAD;
        resp_byte[0] = gpms_pkg::ID_PAD;
        resp_byte[1] = gpms_pkg::ID_READY;
        resp_byte[2] = gpms_pkg::BYTE_IDLE;
        resp_byte[3] = gpms_pkg::BYTE_IDLE;
      end
    endcase
    sum_x = '0;
    sum_y = '0;
  endfunction

  // End of a byte: the first two command bytes must match, or the slave drops out.
  function automatic void close_byte();
    if (byte_cnt == 8'd0) begin
      if (cmd_byte[0] != gpms_pkg::CMD_START) begin
        link_phase = PH_ATT_LOW;
        return;
      end
      latch_reply();
    end else if (byte_cnt == 8'd1 && cmd_byte[1] != gpms_pkg::CMD_POLL) begin
      link_phase = PH_ATT_LOW;
      return;
    end
    if (byte_cnt != gpms_pkg::BYTE_CNT_MAX) byte_cnt = byte_cnt + 8'd1;
    link_phase = PH_CLK_HIGH;
  endfunction

  function automatic void pin_sample(logic att, logic sclk, logic cmd);
    logic [7:0] cur;
    case (link_phase)
      PH_IDLE: begin
        dat_on = 1'b0;
        if (!att) begin
          bit_cnt     = '0;
          byte_cnt    = '0;
          cmd_byte[0] = '0;
          cmd_byte[1] = '0;
          link_phase  = PH_CLK_HIGH;
        end
      end
      PH_CLK_HIGH: begin
        if (!sclk) begin
          link_phase = PH_CLK_LOW;
          if (byte_cnt > 8'd0 && byte_cnt <= resp_size &&
              byte_cnt <= gpms_pkg::RESP_DEPTH) begin
            cur    = resp_byte[byte_cnt - 8'd1];
            dat_on = ~cur[bit_cnt];
          end
        end else if (att) begin
          link_phase = PH_IDLE;
        end
      end
      PH_CLK_LOW: begin
        if (sclk) begin
          link_phase = PH_CLK_HIGH;
          if (cmd && byte_cnt < 8'd2) cmd_byte[byte_cnt[0]][bit_cnt] = 1'b1;
          bit_cnt = bit_cnt + 3'd1;
          if (bit_cnt == 3'd0) begin
            wait_cnt   = ack_delay;
            link_phase = PH_HOLD;
          end
        end else if (att) begin
          link_phase = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (wait_cnt != '0) begin
          wait_cnt = wait_cnt - 1'b1;
        end else begin
          dat_on = 1'b0;
          if (byte_cnt < resp_size && ack_width != '0) begin
            ack_on     = 1'b1;
            wait_cnt   = ack_width - 1'b1;
            link_phase = PH_ACK;
          end else begin
            close_byte();
          end
        end
      end
      PH_ACK: begin
        if (wait_cnt != '0) begin
          wait_cnt = wait_cnt - 1'b1;
        end else begin
          ack_on = 1'b0;
          close_byte();
        end
      end
      default: begin
        dat_on     = 1'b0;
        link_phase = att ? PH_IDLE : PH_ATT_LOW;
      end
    endcase
  endfunction

  // Applies one input beat to the model and returns the line drive it must produce.
  function automatic gpms_pkg::out_item_t predict_line_drive(gpms_pkg::in_item_t item);
    gpms_pkg::out_item_t drive;
    case (item.func)
      gpms_pkg::FUNC_TICK: pin_sample(item.att_level, item.clk_level, item.cmd_level);
      gpms_pkg::FUNC_MOUSE: begin
        sum_x       = sat_sum8(sum_x, item.delta_x);
        sum_y       = sat_sum8(sum_y, item.delta_y);
        left_held   = item.left_button;
        right_held  = item.right_button;
        report_mode = gpms_pkg::MODE_MOUSE;
      end
      gpms_pkg::FUNC_PAD: begin
        sum_x       = '0;
        sum_y       = '0;
        pad_held    = item.pad_buttons;
        report_mode = gpms_pkg::MODE_PAD;
      end
      default: begin
        sum_x       = '0;
        sum_y       = '0;
        report_mode = gpms_pkg::MODE_PAD;
      end
    endcase
    drive.dat_low = dat_on;
    drive.ack_low = ack_on;
    return drive;
  endfunction

  // ------------------------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Each result beat is matched against the oldest expected drive. The values read here are
  // the ones from just before the edge, so the order of processes within the step is irrelevant.
  always @(posedge clk) begin : drive_checker
    gpms_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive_q.size() == 0) begin
        report_mismatch("result beat arrived with nothing expected");
      end else begin
        want = expected_drive_q.pop_front();
        if (out_data.dat_low !== want.dat_low)
          report_mismatch($sformatf("dat_low is %b, expected %b", out_data.dat_low,
                                    want.dat_low));
        if (out_data.ack_low !== want.ack_low)
          report_mismatch($sformatf("ack_low is %b, expected %b", out_data.ack_low,
                                    want.ack_low));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               expected_drive_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The result side draws a stall before every beat it takes. It changes ready only on the
  // falling edge, and it stalls only while idling is enabled.
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ------------------------------------------------------------------------------------------
  // Beat and register drivers
  // ------------------------------------------------------------------------------------------

  // Sends one beat. Valid drops only for a drawn gap, so back-to-back beats keep it high.
  // The expected drive is predicted at the edge that accepts the beat.
  task automatic send_beat(gpms_pkg::in_item_t item);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_drive_q.push_back(predict_line_drive(item));
    beats_sent++;
  endtask

  // Lowers valid and waits for every expected beat to arrive, then for a margin of idle clocks.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [gpms_pkg::TICK_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gpms_pkg::REG_ACK_DELAY) ack_delay = value;
    else ack_width = value;
  endtask

  // Timing changes are made only once the slave has gone quiet.
  task automatic set_ack_timing(logic [gpms_pkg::TICK_W-1:0] delay,
                                logic [gpms_pkg::TICK_W-1:0] width);
    settle();
    cfg_write(gpms_pkg::REG_ACK_DELAY, delay);
    cfg_write(gpms_pkg::REG_ACK_WIDTH, width);
  endtask

  function automatic logic coin();
    return logic'($urandom_range(0, 1));
  endfunction

  // Every field is random, so that the fields a beat does not use still toggle.
  function automatic gpms_pkg::in_item_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(gpms_pkg::in_item_t)-1:0];
  endfunction

  task automatic tick(logic att, logic sclk, logic cmd);
    gpms_pkg::in_item_t item;
    item           = random_item();
    item.func      = gpms_pkg::FUNC_TICK;
    item.att_level = att;
    item.clk_level = sclk;
    item.cmd_level = cmd;
    send_beat(item);
  endtask

  task automatic send_report(gpms_pkg::func_t kind, logic signed [7:0] dx,
                             logic signed [7:0] dy, logic lb, logic rb, logic [15:0] buttons);
    gpms_pkg::in_item_t item;
    item              = random_item();
    item.func         = kind;
    item.delta_x      = dx;
    item.delta_y      = dy;
    item.left_button  = lb;
    item.right_button = rb;
    item.pad_buttons  = buttons;
    send_beat(item);
  endtask

  task automatic random_report();
    send_report(gpms_pkg::func_t'($urandom_range(gpms_pkg::FUNC_MOUSE, gpms_pkg::FUNC_OVERFLOW)),
                8'($urandom), 8'($urandom), coin(), coin(), 16'($urandom));
  endtask

  // One host byte, LSB first: the clock goes low for one or two samples, and each bit is
  // presented at the rising sample. The host then keeps ticking through hold and acknowledge.
  // While the slave waits, the pin levels are random, since it must not look at them then.
  task automatic host_byte(logic [7:0] value, bit mixed);
    for (int i = 0; i < 8; i++) begin
      repeat ($urandom_range(1, 2)) tick(1'b0, 1'b0, coin());
      if (mixed && $urandom_range(0, 3) == 0) random_report();
      tick(1'b0, 1'b1, value[i]);
    end
    while (link_phase == PH_HOLD || link_phase == PH_ACK) begin
      if (mixed && $urandom_range(0, 7) == 0) random_report();
      else tick(coin(), coin(), coin());
    end
  endtask

  // A full exchange. It first walks the slave back to idle with attention high, which may take
  // a rising clock or a wait after noise. Then it selects the slave, sends the bytes and
  // deselects. With mixed set, reports land in the middle of the exchange.
  task automatic exchange(logic [7:0] first, logic [7:0] second, int unsigned nbytes,
                          bit mixed);
    do tick(1'b1, 1'b1, coin()); while (link_phase != PH_IDLE);
    tick(1'b0, 1'b1, coin());
    for (int k = 0; k < nbytes; k++)
      host_byte((k == 0) ? first : (k == 1) ? second : 8'($urandom), mixed);
    tick(1'b1, 1'b1, coin());
  endtask

  // ------------------------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------------------------

  // Out of reset the slave has not yet seen attention high, so a select is ignored. The first
  // real exchange runs at the reset hold and acknowledge timing and answers with the idle reply.
  task automatic test_select_after_reset();
    tick(1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b0, 1'b1, 1'b1);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 2, 1'b0);
  endtask

  // Report extremes: sums driven into both clamps, both button words, and an overflow report.
  // A short hold and acknowledge keep these exchanges brief.
  task automatic test_reports();
    set_ack_timing(10'd1, 10'd1);
    repeat (2) send_report(gpms_pkg::FUNC_MOUSE, 8'sd127, 8'sd127, 1'b1, 1'b0, 16'h0000);
    repeat (3) send_report(gpms_pkg::FUNC_MOUSE, -8'sd128, -8'sd128, 1'b0, 1'b1, 16'hFFFF);
    send_report(gpms_pkg::FUNC_MOUSE, 8'sd127, -8'sd128, 1'b1, 1'b1, 16'h0000);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 6, 1'b0);
    send_report(gpms_pkg::FUNC_PAD, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 4, 1'b0);
    send_report(gpms_pkg::FUNC_PAD, -8'sd1, 8'sd1, 1'b1, 1'b1, 16'hFFFF);
    send_report(gpms_pkg::FUNC_OVERFLOW, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 4, 1'b0);
  endtask

  // A wrong first or second command byte must make the slave drop out of the exchange.
  task automatic test_bad_command();
    exchange(8'h81, gpms_pkg::CMD_POLL, 3, 1'b0);
    exchange(gpms_pkg::CMD_START, 8'h43, 4, 1'b0);
  endtask

  // Reports during an exchange change state at once but not the drive of that beat.
  task automatic test_reports_mid_exchange();
    send_report(gpms_pkg::FUNC_MOUSE, 8'sd3, -8'sd7, 1'b0, 1'b1, 16'h1234);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 6, 1'b1);
  endtask

  // Attention going high during a low clock, and during a high clock, ends the exchange.
  task automatic test_attention_abort();
    do tick(1'b1, 1'b1, 1'b0); while (link_phase != PH_IDLE);
    tick(1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b1, 1'b0, 1'b0);
    tick(1'b0, 1'b1, 1'b1);
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b0, 1'b1, 1'b1);
    tick(1'b1, 1'b1, 1'b0);
  endtask

  // A hold long enough to need the top bit of the hold counter, then no hold and no pulse at
  // all, then the shortest pulse.
  task automatic test_ack_timing_extremes();
    set_ack_timing(10'd513, 10'd1);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 1, 1'b0);
    set_ack_timing(10'd0, 10'd0);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 6, 1'b0);
    set_ack_timing(10'd0, 10'd1);
    exchange(gpms_pkg::CMD_START, gpms_pkg::CMD_POLL, 4, 1'b0);
  endtask

  // Mostly well-formed exchanges with random content and lengths, now and then with bad
  // command bytes. Mixed in are report bursts, pin noise and timing changes with small values.
  // Idling is sometimes switched off for a stretch.
  task automatic test_random_traffic();
    int unsigned first_beat;
    int unsigned pick;
    first_beat = beats_sent;
    set_ack_timing(10'($urandom_range(0, 8)), 10'($urandom_range(0, 8)));
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        set_ack_timing(10'($urandom_range(0, 12)), 10'($urandom_range(0, 12)));
        idle_on = ($urandom_range(0, 3) != 0);
      end else if (pick < 30) begin
        repeat ($urandom_range(1, 3)) random_report();
      end else if (pick < 40) begin
        repeat ($urandom_range(1, 12)) tick(coin(), coin(), coin());
      end else begin
        exchange(($urandom_range(0, 9) != 0) ? gpms_pkg::CMD_START : 8'($urandom),
                 ($urandom_range(0, 9) != 0) ? gpms_pkg::CMD_POLL : 8'($urandom),
                 $urandom_range(1, 8), $urandom_range(0, 2) == 0);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = gpms_pkg::REG_ACK_DELAY;
    cfg_wdata      = '0;
    idle_on        = 1'b1;
    mismatch_count = 0;
    beats_sent     = 0;
    cycle_count    = 0;
    reset_link_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_select_after_reset();
    test_reports();
    test_bad_command();
    test_reports_mid_exchange();
    test_attention_abort();
    test_ack_timing_extremes();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/gpms_pkg.sv
rtl/gpms_report.sv
rtl/gpms_link.sv
rtl/game_pad_mouse_serial_slave_top.sv
rtl/gpms_checker.sv
tb/sv/testbench.sv
